>>> rtl/mcdb_pkg.sv
// Package for the multi-class deque bank: sizes, word types, result codes
// and the control word shared by the fill tracker, the slot cells and the top.
// No dependencies.
package mcdb_pkg;

    localparam int NUM_CLASSES = 20;
    localparam int QUEUE_DEPTH = 5;
    localparam int ID_WIDTH    = 32;

    // Fixed field widths of the request and response words
    localparam int CLS_W     = 5;
    localparam int IN_ID_W   = 32;
    localparam int OUT_ID_W  = 32;
    localparam int OUT_FILL_W = 3;

    // Derived internal widths
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // Request types
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_POP = 1'b1;

    // Result codes
    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_FULL      = 2'd1;
    localparam logic [1:0] RC_EMPTY     = 2'd2;
    localparam logic [1:0] RC_BAD_CLASS = 2'd3;

    typedef struct packed {
        logic                req_type;
        logic [CLS_W-1:0]    class_index;
        logic                urgent;
        logic [IN_ID_W-1:0]  entry_id;
    } req_t;

    typedef struct packed {
        logic [1:0]            result_code;
        logic [OUT_ID_W-1:0]   popped_id;
        logic                  popped_urgent;
        logic [OUT_FILL_W-1:0] queue_fill;
    } rsp_t;

    typedef struct packed {
        logic                urgent;
        logic [ID_WIDTH-1:0] id;
    } entry_t;

    // Control word from the fill tracker to the slot cells and the top
    typedef struct packed {
        logic              pop_ok;     // accepted pop of a non-empty queue
        logic              add_ok;     // accepted add to a non-full queue
        logic              urgent;     // add goes to the head
        logic [CIDX_W-1:0] cls;        // class addressed (0 when bad)
        logic [FILL_W-1:0] count;      // entries before the request
        logic [1:0]        code;       // result code
        logic [FILL_W-1:0] fill_after; // reported fill
    } ctrl_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } cell_op_t;

endpackage

>>> rtl/multi_class_deque_bank.sv
// Top level of the multi-class deque bank: fill tracker, a row of slot cells
// and the response register. Depends on mcdb_pkg, mcdb_fill and mcdb_cell.
//
// One request word is taken on every clock in which start is high; busy never
// rises, so a request may follow on every cycle. The response word appears on
// rsp one cycle after its request, with done high for that single cycle, and
// must be taken then: there is no back pressure. The whole request (count
// lookup, slot moves through the cell row, count update) finishes in the
// accepting cycle, so back-to-back requests to the same class see each
// other's effects. Each class queue is a chain of QUEUE_DEPTH cells: a pop
// shifts every entry one cell toward the head, an urgent add shifts them one
// cell toward the tail and loads the head, a regular add loads the cell at the
// current fill. Slot contents are not reset; only slots below a class's fill
// are ever read.
module multi_class_deque_bank (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mcdb_pkg::req_t req,
    output logic           done,
    output mcdb_pkg::rsp_t rsp
);
    import mcdb_pkg::*;

    logic   accept;
    ctrl_t  ctrl;
    entry_t new_entry;
    entry_t cell_rd [QUEUE_DEPTH];
    logic   done_reg;
    logic   done_next;
    rsp_t   rsp_reg;
    rsp_t   rsp_next;

    // Never stall: every request finishes within its accepting cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    mcdb_fill u_fill (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .ctrl   (ctrl)
    );

    // Urgent adds carry the urgent mark into the head slot
    assign new_entry.id     = ID_WIDTH'(req.entry_id);
    assign new_entry.urgent = req.urgent;

    // Row of slot cells; each cell sees its neighbors' words for the class
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        entry_t prev_w;
        entry_t next_w;

        if (g == 0)
        begin : g_head
            assign prev_w = '0;
        end
        else
        begin : g_mid
            assign prev_w = cell_rd[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_w = '0;
        end
        else
        begin : g_body
            assign next_w = cell_rd[g+1];
        end

        mcdb_cell u_cell (
            .clk        (clk),
            .slot_index (SLOT_W'(g)),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_w),
            .next_entry (next_w),
            .rd_entry   (cell_rd[g])
        );
    end

    // Build the response word; popped fields only on a successful pop
    always_comb
    begin
        done_next            = accept;
        rsp_next             = '0;
        rsp_next.result_code = ctrl.code;
        rsp_next.queue_fill  = OUT_FILL_W'(ctrl.fill_after);
        if (ctrl.pop_ok)
        begin
            rsp_next.popped_id     = OUT_ID_W'(cell_rd[0].id);
            rsp_next.popped_urgent = cell_rd[0].urgent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Hold the payload until the next accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A response follows every accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted request produced no response");

    // Failed requests report no popped entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.result_code != RC_OK) |->
            (rsp.popped_id == '0 && !rsp.popped_urgent))
        else $error("popped fields set on a failed request");

    // A bad class reports an empty fill
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.result_code == RC_BAD_CLASS) |-> rsp.queue_fill == '0)
        else $error("bad class reported a nonzero fill");

endmodule

>>> rtl/mcdb_fill.sv
// Fill tracker: per-class entry counts, request decode and result code.
// Depends on mcdb_pkg.
module mcdb_fill (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  mcdb_pkg::req_t req,
    output mcdb_pkg::ctrl_t ctrl
);
    import mcdb_pkg::*;

    logic [FILL_W-1:0] fill_reg [NUM_CLASSES];
    logic              bad_class;
    logic [CIDX_W-1:0] cidx;
    logic [FILL_W-1:0] n;

    assign bad_class = ({1'b0, req.class_index} >= (CLS_W + 1)'(NUM_CLASSES));
    assign cidx      = bad_class ? '0 : req.class_index[CIDX_W-1:0];
    assign n         = fill_reg[cidx];

    always_comb
    begin
        ctrl        = '0;
        ctrl.cls    = cidx;
        ctrl.count  = n;
        ctrl.urgent = req.urgent;
        if (bad_class)
        begin
            ctrl.code = RC_BAD_CLASS;
        end
        else if (req.req_type == REQ_POP)
        begin
            if (n == '0)
            begin
                ctrl.code = RC_EMPTY;
            end
            else
            begin
                ctrl.code       = RC_OK;
                ctrl.pop_ok     = accept;
                ctrl.fill_after = n - FILL_W'(1);
            end
        end
        else
        begin
            if (n >= FILL_W'(QUEUE_DEPTH))
            begin
                ctrl.code       = RC_FULL;
                ctrl.fill_after = n;
            end
            else
            begin
                ctrl.code       = RC_OK;
                ctrl.add_ok     = accept;
                ctrl.fill_after = n + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (ctrl.pop_ok || ctrl.add_ok)
        begin
            fill_reg[cidx] <= ctrl.fill_after;
        end
    end

    // A request never both adds and pops
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.pop_ok, ctrl.add_ok}))
        else $error("add and pop in the same cycle");

    // The addressed count stays within the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        n <= FILL_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    // A successful add advances the count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.add_ok |=> fill_reg[$past(cidx)] == $past(n) + FILL_W'(1))
        else $error("add did not advance the fill count");

endmodule

>>> rtl/mcdb_cell.sv
// Slot cell: holds one slot position of every class queue and takes its
// next word from the request, from the cell before it or the cell after it.
// Depends on mcdb_pkg.
module mcdb_cell (
    input  logic                    clk,
    input  logic [mcdb_pkg::SLOT_W-1:0] slot_index,
    input  mcdb_pkg::ctrl_t         ctrl,
    input  mcdb_pkg::entry_t        new_entry,
    input  mcdb_pkg::entry_t        prev_entry,
    input  mcdb_pkg::entry_t        next_entry,
    output mcdb_pkg::entry_t        rd_entry
);
    import mcdb_pkg::*;

    entry_t            slots_reg [NUM_CLASSES];
    cell_op_t          op;
    entry_t            wr_data;
    logic [FILL_W-1:0] k;

    assign k        = FILL_W'(slot_index);
    assign rd_entry = slots_reg[ctrl.cls];

    always_comb
    begin
        op = CELL_HOLD;
        if (ctrl.pop_ok)
        begin
            if ((k + FILL_W'(1)) < ctrl.count)
            begin
                op = CELL_FROM_NEXT;
            end
        end
        else if (ctrl.add_ok)
        begin
            if (ctrl.urgent)
            begin
                if (k == '0)
                begin
                    op = CELL_LOAD;
                end
                else if (k <= ctrl.count)
                begin
                    op = CELL_FROM_PREV;
                end
            end
            else if (k == ctrl.count)
            begin
                op = CELL_LOAD;
            end
        end
    end

    always_comb
    begin
        case (op)
            CELL_LOAD:      wr_data = new_entry;
            CELL_FROM_PREV: wr_data = prev_entry;
            CELL_FROM_NEXT: wr_data = next_entry;
            default:        wr_data = rd_entry;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op != CELL_HOLD)
        begin
            slots_reg[ctrl.cls] <= wr_data;
        end
    end

endmodule
